### rtl/core/lslvu_pkg.sv
// Shared types, constants and helpers of the level set layer value update unit.
package lslvu_pkg;

  localparam int unsigned LAYER_COUNT = 5;
  localparam int unsigned NEIGHBOURS  = 6;
  localparam int unsigned MaxNbrs     = 6;

  localparam int unsigned PassW  = 4;
  localparam int unsigned StatW  = 8;
  localparam int unsigned LayerW = 4;
  localparam int unsigned ValW   = 16;
  localparam int unsigned StepW  = 15;
  localparam int unsigned ActW   = 2;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [StepW-1:0] GradStepReset = 15'd256;
  localparam logic [StatW-1:0] StatNullReset = 8'd255;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgGradStep = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgStatNull = 1'b1;

  typedef enum logic [ActW-1:0] {
    ActUnlink  = 2'd0,
    ActValue   = 2'd1,
    ActPromote = 2'd2,
    ActDelete  = 2'd3
  } action_e;

  // candidate neighbour value; vld set when the neighbour sits in the 'from' layer
  typedef struct packed {
    logic                   vld;
    logic signed [ValW-1:0] val;
  } cand_t;

  // per-node control carried alongside the value reduction
  typedef struct packed {
    logic              stale;
    logic              delete_node;
    logic              inward;
    logic [StatW-1:0]  center;
    logic [LayerW-1:0] to_layer;
    logic [LayerW-1:0] promote;
  } node_ctl_t;

  // largest (inward) or smallest (outward) of two candidates, ignoring empty ones
  function automatic cand_t pick_cand(cand_t a, cand_t b, logic inward);
    cand_t r;
    r = a;
    if (!a.vld) begin
      r = b;
    end else if (b.vld) begin
      if (inward ? ($signed(b.val) > $signed(a.val)) : ($signed(b.val) < $signed(a.val))) begin
        r = b;
      end
    end
    return r;
  endfunction

endpackage

### rtl/core/lslvu_decode.sv
// Stage 1: pass decode, stale check and neighbour layer match.
module lslvu_decode #(
  parameter int unsigned NBRS = lslvu_pkg::NEIGHBOURS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [lslvu_pkg::PassW-1:0]         pass_i,
  input  logic [lslvu_pkg::StatW-1:0]         center_i,
  input  logic [6*lslvu_pkg::StatW-1:0]       nbr_status_i,
  input  logic signed [lslvu_pkg::ValW-1:0]   nbr_val_i [lslvu_pkg::MaxNbrs],
  output logic                                valid_o,
  input  logic                                ready_i,
  output lslvu_pkg::node_ctl_t                ctl_o,
  output lslvu_pkg::cand_t                    cand_o [NBRS]
);

  logic                                pass_ok;
  logic [lslvu_pkg::PassW-1:0]         from_layer;
  logic [lslvu_pkg::LayerW-1:0]        to_layer;
  logic [lslvu_pkg::LayerW:0]          promote;
  lslvu_pkg::node_ctl_t                ctl_d, ctl_q;
  lslvu_pkg::cand_t                    cand_d [NBRS];
  lslvu_pkg::cand_t                    cand_q [NBRS];
  logic                                vld_q;

  assign pass_ok    = pass_i <= lslvu_pkg::PassW'(lslvu_pkg::LAYER_COUNT - 2);
  // passes 0 and 1 both read layer 0; later passes read layer pass-1
  assign from_layer = (pass_i < 4'd2) ? '0 : pass_i - 4'd1;
  assign to_layer   = pass_i + 4'd1;
  assign promote    = {1'b0, pass_i} + 5'd3;

  always_comb begin
    ctl_d.stale       = center_i != {{(lslvu_pkg::StatW-lslvu_pkg::LayerW){1'b0}}, to_layer};
    ctl_d.delete_node = promote > 5'(lslvu_pkg::LAYER_COUNT - 1);
    ctl_d.inward      = ~pass_i[0];
    ctl_d.center      = center_i;
    ctl_d.to_layer    = to_layer;
    ctl_d.promote     = promote[lslvu_pkg::LayerW-1:0];
    for (int i = 0; i < NBRS; i++) begin
      cand_d[i].vld = nbr_status_i[i*lslvu_pkg::StatW +: lslvu_pkg::StatW] ==
                      {{(lslvu_pkg::StatW-lslvu_pkg::PassW){1'b0}}, from_layer};
      cand_d[i].val = nbr_val_i[i];
    end
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      // out-of-range passes are dropped here
      vld_q <= valid_i && pass_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctl_q  <= ctl_d;
      cand_q <= cand_d;
    end
  end

  assign valid_o = vld_q;
  assign ctl_o   = ctl_q;
  assign cand_o  = cand_q;

endmodule

### rtl/core/lslvu_reduce.sv
// Stages 2 and 3: registered max/min tree over the matching neighbours.
module lslvu_reduce #(
  parameter int unsigned NBRS = lslvu_pkg::NEIGHBOURS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  lslvu_pkg::node_ctl_t ctl_i,
  input  lslvu_pkg::cand_t     cand_i [NBRS],
  output logic                 valid_o,
  input  logic                 ready_i,
  output lslvu_pkg::node_ctl_t ctl_o,
  output lslvu_pkg::cand_t     best_o
);

  localparam int unsigned NumPairs = (NBRS + 1) / 2;

  lslvu_pkg::cand_t     pair_d [NumPairs];
  lslvu_pkg::cand_t     pair_q [NumPairs];
  lslvu_pkg::node_ctl_t ctl2_q, ctl3_q;
  lslvu_pkg::cand_t     best_d, best_q;
  logic                 vld2_q, vld3_q;
  logic                 rdy2, rdy3;

  for (genvar j = 0; j < NumPairs; j++) begin : g_pair
    if (2*j + 1 < NBRS) begin : g_two
      assign pair_d[j] = lslvu_pkg::pick_cand(cand_i[2*j], cand_i[2*j+1], ctl_i.inward);
    end else begin : g_one
      assign pair_d[j] = cand_i[2*j];
    end
  end

  // at most three pair winners left, folded in one stage
  always_comb begin
    best_d = pair_q[0];
    for (int j = 1; j < NumPairs; j++) begin
      best_d = lslvu_pkg::pick_cand(best_d, pair_q[j], ctl2_q.inward);
    end
  end

  assign rdy3    = !vld3_q || ready_i;
  assign rdy2    = !vld2_q || rdy3;
  assign ready_o = rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      if (rdy2) begin
        vld2_q <= valid_i;
      end
      if (rdy3) begin
        vld3_q <= vld2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy2) begin
      pair_q <= pair_d;
      ctl2_q <= ctl_i;
    end
    if (vld2_q && rdy3) begin
      best_q <= best_d;
      ctl3_q <= ctl2_q;
    end
  end

  assign valid_o = vld3_q;
  assign ctl_o   = ctl3_q;
  assign best_o  = best_q;

endmodule

### rtl/core/lslvu_update.sv
// Stage 4: saturating step add, action select and output register.
module lslvu_update (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  lslvu_pkg::node_ctl_t                ctl_i,
  input  lslvu_pkg::cand_t                    best_i,
  input  logic [lslvu_pkg::StepW-1:0]         grad_step_i,
  input  logic [lslvu_pkg::StatW-1:0]         stat_null_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output lslvu_pkg::action_e                  action_o,
  output logic signed [lslvu_pkg::ValW-1:0]   new_value_o,
  output logic [lslvu_pkg::StatW-1:0]         new_status_o,
  output logic [lslvu_pkg::LayerW-1:0]        target_layer_o
);

  logic signed [lslvu_pkg::ValW+1:0]   best_ext, step_ext, sum;
  logic signed [lslvu_pkg::ValW-1:0]   sat;
  lslvu_pkg::action_e                  action_d, action_q;
  logic signed [lslvu_pkg::ValW-1:0]   value_d, value_q;
  logic [lslvu_pkg::StatW-1:0]         status_d, status_q;
  logic [lslvu_pkg::LayerW-1:0]        layer_q;
  logic                                vld_q;

  assign best_ext = {{2{best_i.val[lslvu_pkg::ValW-1]}}, best_i.val};
  assign step_ext = {3'b000, grad_step_i};
  assign sum      = ctl_i.inward ? best_ext - step_ext : best_ext + step_ext;

  always_comb begin
    if (sum > 18'sd32767) begin
      sat = 16'sh7FFF;
    end else if (sum < -18'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[lslvu_pkg::ValW-1:0];
    end
  end

  always_comb begin
    action_d = lslvu_pkg::ActUnlink;
    value_d  = '0;
    status_d = ctl_i.center;
    if (ctl_i.stale) begin
      action_d = lslvu_pkg::ActUnlink;
    end else if (best_i.vld) begin
      action_d = lslvu_pkg::ActValue;
      value_d  = sat;
    end else if (ctl_i.delete_node) begin
      action_d = lslvu_pkg::ActDelete;
      status_d = stat_null_i;
    end else begin
      action_d = lslvu_pkg::ActPromote;
      status_d = {{(lslvu_pkg::StatW-lslvu_pkg::LayerW){1'b0}}, ctl_i.promote};
    end
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      action_q <= action_d;
      value_q  <= value_d;
      status_q <= status_d;
      layer_q  <= ctl_i.to_layer;
    end
  end

  assign valid_o        = vld_q;
  assign action_o       = action_q;
  assign new_value_o    = value_q;
  assign new_status_o   = status_q;
  assign target_layer_o = layer_q;

endmodule

### rtl/core/level_set_layer_value_update_unit.sv
// Pipeline: an accepted item passes the decode, pair, fold and update stage registers in order to reach m_axis.
// Throughput: one item per cycle while m_axis_tready is high; each of the four stage registers has its own valid bit
// and takes a new item whenever it is empty or its successor takes its contents.
// Items with a pass index above LAYER_COUNT-2 are dropped in the decode stage.
// Reset (rst_ni low, asynchronous) empties all stages; gradient_step returns to 256
// and status_null to 255.
module level_set_layer_value_update_unit #(
  parameter int unsigned NEIGHBOURS = lslvu_pkg::NEIGHBOURS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // center_status[7:0], nbr_statuses[55:8], nbr_value_0..5 at [71:56] up to [151:136]
  input  logic [151:0]                         s_axis_tdata,
  // pass_index[3:0]
  input  logic [lslvu_pkg::PassW-1:0]          s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // new_value[15:0], new_status[23:16], target_layer[27:24], zero[31:28]
  output logic [31:0]                          m_axis_tdata,
  // action[1:0]
  output logic [lslvu_pkg::ActW-1:0]           m_axis_tuser,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lslvu_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [lslvu_pkg::StepW-1:0]          cfg_data_i
);

  localparam int unsigned NbrBase = lslvu_pkg::StatW + 6*lslvu_pkg::StatW;

  logic [lslvu_pkg::StepW-1:0]         grad_step_q;
  logic [lslvu_pkg::StatW-1:0]         stat_null_q;

  logic signed [lslvu_pkg::ValW-1:0]   nbr_val [lslvu_pkg::MaxNbrs];
  logic                                dec_vld, dec_rdy;
  lslvu_pkg::node_ctl_t                dec_ctl;
  lslvu_pkg::cand_t                    dec_cand [NEIGHBOURS];
  logic                                red_vld, red_rdy;
  lslvu_pkg::node_ctl_t                red_ctl;
  lslvu_pkg::cand_t                    red_best;
  lslvu_pkg::action_e                  action;
  logic signed [lslvu_pkg::ValW-1:0]   new_value;
  logic [lslvu_pkg::StatW-1:0]         new_status;
  logic [lslvu_pkg::LayerW-1:0]        target_layer;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grad_step_q <= lslvu_pkg::GradStepReset;
      stat_null_q <= lslvu_pkg::StatNullReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lslvu_pkg::CfgGradStep: grad_step_q <= cfg_data_i;
        lslvu_pkg::CfgStatNull: stat_null_q <= cfg_data_i[lslvu_pkg::StatW-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < lslvu_pkg::MaxNbrs; i++) begin : g_val
    assign nbr_val[i] = s_axis_tdata[NbrBase + i*lslvu_pkg::ValW +: lslvu_pkg::ValW];
  end

  lslvu_decode #(
    .NBRS (NEIGHBOURS)
  ) u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .pass_i       (s_axis_tuser),
    .center_i     (s_axis_tdata[lslvu_pkg::StatW-1:0]),
    .nbr_status_i (s_axis_tdata[NbrBase-1:lslvu_pkg::StatW]),
    .nbr_val_i    (nbr_val),
    .valid_o      (dec_vld),
    .ready_i      (dec_rdy),
    .ctl_o        (dec_ctl),
    .cand_o       (dec_cand)
  );

  lslvu_reduce #(
    .NBRS (NEIGHBOURS)
  ) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_vld),
    .ready_o (dec_rdy),
    .ctl_i   (dec_ctl),
    .cand_i  (dec_cand),
    .valid_o (red_vld),
    .ready_i (red_rdy),
    .ctl_o   (red_ctl),
    .best_o  (red_best)
  );

  lslvu_update u_update (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (red_vld),
    .ready_o        (red_rdy),
    .ctl_i          (red_ctl),
    .best_i         (red_best),
    .grad_step_i    (grad_step_q),
    .stat_null_i    (stat_null_q),
    .valid_o        (m_axis_tvalid),
    .ready_i        (m_axis_tready),
    .action_o       (action),
    .new_value_o    (new_value),
    .new_status_o   (new_status),
    .target_layer_o (target_layer)
  );

  assign m_axis_tuser = action;
  assign m_axis_tdata = {4'b0000, target_layer, new_status, new_value};

  // an in-range item always lands in the decode stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready &&
    s_axis_tuser <= lslvu_pkg::PassW'(lslvu_pkg::LAYER_COUNT - 2) |=> dec_vld)
    else $error("in-range item lost in decode stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != lslvu_pkg::ActValue |-> m_axis_tdata[15:0] == '0)
    else $error("new_value nonzero for a non-value action");

  // promote layer is always two past the target layer and within range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == lslvu_pkg::ActPromote |->
    m_axis_tdata[23:16] == {4'b0000, m_axis_tdata[27:24]} + 8'd2 &&
    m_axis_tdata[23:16] <= 8'(lslvu_pkg::LAYER_COUNT - 1))
    else $error("promoted status inconsistent with target layer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == lslvu_pkg::ActDelete |->
    m_axis_tdata[23:16] == stat_null_q)
    else $error("deleted node without null status");

endmodule
